@@ hw/rtl/iub_pkg.sv @@
// shared types, constants and helpers of the integer upscale blitter
`default_nettype none

package iub_pkg;

  // fixed field widths
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned ADDR_W     = 22;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned SCR_CFG_W  = 12;
  localparam int unsigned SRC_CFG_W  = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd3;

  // register reset values
  localparam logic [SCR_CFG_W-1:0] SCREEN_WIDTH_RST  = 12'd1920;
  localparam logic [SCR_CFG_W-1:0] SCREEN_HEIGHT_RST = 12'd1080;
  localparam logic [SRC_CFG_W-1:0] SOURCE_WIDTH_RST  = 10'd320;
  localparam logic [SRC_CFG_W-1:0] SOURCE_HEIGHT_RST = 10'd180;

  // controller to datapath commands
  typedef struct packed {
    logic cfg_we;
    logic derive_init;
    logic derive_step;
    logic derive_finish;
    logic pix_load;
    logic setup;
    logic emit;
  } iub_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic derive_done;
    logic run_empty;
    logic last_write;
    logic out_free;
  } iub_sts_t;

  // rgb565 to 24-bit color by shifting, low bits left at zero
  function automatic logic [COLOR_W-1:0] widen_rgb565(input logic [PIX_W-1:0] px);
    return {px[15:11], 3'b000, px[10:5], 2'b00, px[4:0], 3'b000};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/integer_upscale_rgb565_blitter_top.sv @@
// top level of the integer upscale blitter
`default_nettype none

// Takes RGB565 source pixels in raster order and turns each into a clipped
// scale x scale block of back-buffer writes (address and 24-bit color), with
// last_of_run on the final write of a pixel and frame_done on the final write
// of a frame's last pixel. The scale is the largest integer up to MAX_SCALE at
// which the source fits the screen (at least 1) and the image is centered.
// Per pixel: the block accepts it, runs a setup state, then loads one write per cycle
// into the output register while that register is free; a clipped pixel loads only
// its kept writes and a fully clipped one none. After reset and after every register
// write, the scale search steps once per candidate scale, and no pixel is taken until
// it has finished and the centering offsets are set.

module integer_upscale_rgb565_blitter_top
  import iub_pkg::*;
#(
  parameter int unsigned MAX_SCREEN_W   = 2048,
  parameter int unsigned MAX_SCREEN_H   = 2048,
  parameter int unsigned MAX_SOURCE_DIM = 512,
  parameter int unsigned MAX_SCALE      = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      source_pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ADDR_W-1:0]     write_address_o,
  output logic [COLOR_W-1:0]    write_color_o,
  output logic                  last_of_run_o,
  output logic                  frame_done_o
);

  iub_cmd_t cmd;
  iub_sts_t sts;

  // controller
  iub_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  iub_dp #(
    .MAX_SCREEN_W   (MAX_SCREEN_W),
    .MAX_SCREEN_H   (MAX_SCREEN_H),
    .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
    .MAX_SCALE      (MAX_SCALE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .source_pixel_i  (source_pixel_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .write_address_o (write_address_o),
    .write_color_o   (write_color_o),
    .last_of_run_o   (last_of_run_o),
    .frame_done_o    (frame_done_o)
  );

  // a register write restarts the scale search, which blocks pixels
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> !in_ready_o)
    else $error("pixel accepted right after a register write");

  // an accepted pixel is followed by its setup cycle
  a_accept_then_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd.setup)
    else $error("no setup after pixel accept");

  // a write is only loaded when the output register can take it
  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("write overran a held output word");

  // frame end only marks the last write of a run
  a_frame_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> last_of_run_o)
    else $error("frame_done without last_of_run");

endmodule

`default_nettype wire

@@ hw/rtl/iub_ctrl.sv @@
// controller state machine of the integer upscale blitter
`default_nettype none

module iub_ctrl
  import iub_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  iub_sts_t sts_i,
  output iub_cmd_t cmd_o
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_DERIVE = 3'd1;
  localparam logic [2:0] ST_FINISH = 3'd2;
  localparam logic [2:0] ST_IDLE   = 3'd3;
  localparam logic [2:0] ST_SETUP  = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.derive_init = 1'b1;
        state_d           = ST_DERIVE;
      end
      ST_DERIVE: begin
        cmd_o.derive_step = 1'b1;
        if (sts_i.derive_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.derive_finish = 1'b1;
        state_d             = ST_IDLE;
      end
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_we = 1'b1;
          state_d      = ST_INIT;
        end else if (in_valid_i) begin
          cmd_o.pix_load = 1'b1;
          state_d        = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.run_empty) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_write) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/iub_dp.sv @@
// datapath of the integer upscale blitter: registers, scale search, counters, write walk
`default_nettype none

module iub_dp
  import iub_pkg::*;
#(
  parameter int unsigned MAX_SCREEN_W   = 2048,
  parameter int unsigned MAX_SCREEN_H   = 2048,
  parameter int unsigned MAX_SOURCE_DIM = 512,
  parameter int unsigned MAX_SCALE      = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iub_cmd_t              cmd_i,
  output iub_sts_t              sts_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PIX_W-1:0]      source_pixel_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [ADDR_W-1:0]     write_address_o,
  output logic [COLOR_W-1:0]    write_color_o,
  output logic                  last_of_run_o,
  output logic                  frame_done_o
);

  localparam int unsigned SW_W  = $clog2(MAX_SCREEN_W + 1);
  localparam int unsigned SH_W  = $clog2(MAX_SCREEN_H + 1);
  localparam int unsigned IW_W  = $clog2(MAX_SOURCE_DIM + 1);
  localparam int unsigned CNT_W = $clog2(MAX_SOURCE_DIM);
  localparam int unsigned S_W   = $clog2(MAX_SCALE + 1);
  localparam int unsigned ACC_W = $clog2(MAX_SOURCE_DIM * MAX_SCALE + 1);
  localparam int unsigned WX_W  = (ACC_W > SW_W) ? ACC_W : SW_W;
  localparam int unsigned WY_W  = (ACC_W > SH_W) ? ACC_W : SH_W;
  localparam int unsigned X_W   = $clog2(MAX_SCREEN_W + MAX_SOURCE_DIM * MAX_SCALE + 1);
  localparam int unsigned Y_W   = $clog2(MAX_SCREEN_H + MAX_SOURCE_DIM * MAX_SCALE + 1);
  localparam int unsigned P_W   = CNT_W + S_W;
  localparam int unsigned RA_W  = Y_W + SW_W;

  // configuration registers
  logic [SCR_CFG_W-1:0] scr_w_q, scr_h_q;
  logic [SRC_CFG_W-1:0] src_w_q, src_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= SCREEN_WIDTH_RST;
      scr_h_q <= SCREEN_HEIGHT_RST;
      src_w_q <= SOURCE_WIDTH_RST;
      src_h_q <= SOURCE_HEIGHT_RST;
    end else if (cmd_i.cfg_we) begin
      unique case (cfg_index_i)
        REG_SCREEN_WIDTH:  scr_w_q <= cfg_data_i[SCR_CFG_W-1:0];
        REG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i[SCR_CFG_W-1:0];
        REG_SOURCE_WIDTH:  src_w_q <= cfg_data_i[SRC_CFG_W-1:0];
        REG_SOURCE_HEIGHT: src_h_q <= cfg_data_i[SRC_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes clamped to 1 .. maximum
  logic [SW_W-1:0] sw_c;
  logic [SH_W-1:0] sh_c;
  logic [IW_W-1:0] iw_c, ih_c;

  always_comb begin
    if (scr_w_q == '0) begin
      sw_c = SW_W'(1);
    end else if (32'(scr_w_q) > 32'(MAX_SCREEN_W)) begin
      sw_c = SW_W'(MAX_SCREEN_W);
    end else begin
      sw_c = SW_W'(scr_w_q);
    end
    if (scr_h_q == '0) begin
      sh_c = SH_W'(1);
    end else if (32'(scr_h_q) > 32'(MAX_SCREEN_H)) begin
      sh_c = SH_W'(MAX_SCREEN_H);
    end else begin
      sh_c = SH_W'(scr_h_q);
    end
    if (src_w_q == '0) begin
      iw_c = IW_W'(1);
    end else if (32'(src_w_q) > 32'(MAX_SOURCE_DIM)) begin
      iw_c = IW_W'(MAX_SOURCE_DIM);
    end else begin
      iw_c = IW_W'(src_w_q);
    end
    if (src_h_q == '0) begin
      ih_c = IW_W'(1);
    end else if (32'(src_h_q) > 32'(MAX_SOURCE_DIM)) begin
      ih_c = IW_W'(MAX_SOURCE_DIM);
    end else begin
      ih_c = IW_W'(src_h_q);
    end
  end

  // scale search: try k = 1, 2, .. up to MAX_SCALE while k times the source size fits the screen
  logic [S_W-1:0]   k_q, scale_q;
  logic [ACC_W-1:0] acc_w_q, acc_h_q, accs_w_q, accs_h_q;
  logic [SW_W-1:0]  off_x_q;
  logic [SH_W-1:0]  off_y_q;
  logic             fit;
  logic             derive_done;
  logic [WX_W-1:0]  fin_sw, fin_aw;
  logic [WY_W-1:0]  fin_sh, fin_ah;

  always_comb begin
    fit = (WX_W'(acc_w_q) <= WX_W'(sw_c)) && (WY_W'(acc_h_q) <= WY_W'(sh_c));
    derive_done = !fit || (k_q == S_W'(MAX_SCALE));
    fin_sw = WX_W'(sw_c);
    fin_aw = WX_W'(accs_w_q);
    fin_sh = WY_W'(sh_c);
    fin_ah = WY_W'(accs_h_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.derive_init) begin
      k_q      <= S_W'(1);
      scale_q  <= S_W'(1);
      acc_w_q  <= ACC_W'(iw_c);
      acc_h_q  <= ACC_W'(ih_c);
      accs_w_q <= ACC_W'(iw_c);
      accs_h_q <= ACC_W'(ih_c);
    end else if (cmd_i.derive_step) begin
      if (fit) begin
        scale_q  <= k_q;
        accs_w_q <= acc_w_q;
        accs_h_q <= acc_h_q;
      end
      if (!derive_done) begin
        k_q     <= k_q + S_W'(1);
        acc_w_q <= acc_w_q + ACC_W'(iw_c);
        acc_h_q <= acc_h_q + ACC_W'(ih_c);
      end
    end
    // centering offsets, zero where the image does not fit
    if (cmd_i.derive_finish) begin
      off_x_q <= (fin_aw <= fin_sw) ? SW_W'((fin_sw - fin_aw) >> 1) : '0;
      off_y_q <= (fin_ah <= fin_sh) ? SH_W'((fin_sh - fin_ah) >> 1) : '0;
    end
  end

  // source position counters
  logic [CNT_W-1:0] col_q, row_q;
  logic             end_line, end_frame;
  logic [P_W-1:0]   col_prod, row_prod;
  logic [X_W-1:0]   x0_new;
  logic [Y_W-1:0]   y0_new;

  always_comb begin
    end_line  = (32'(col_q) + 32'd1) >= 32'(iw_c);
    end_frame = end_line && ((32'(row_q) + 32'd1) >= 32'(ih_c));
    col_prod  = P_W'(col_q) * P_W'(scale_q);
    row_prod  = P_W'(row_q) * P_W'(scale_q);
    x0_new    = X_W'(off_x_q) + X_W'(col_prod);
    y0_new    = Y_W'(off_y_q) + Y_W'(row_prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.pix_load) begin
      if (end_line) begin
        col_q <= '0;
        row_q <= end_frame ? '0 : row_q + CNT_W'(1);
      end else begin
        col_q <= col_q + CNT_W'(1);
      end
    end
  end

  // pixel word, block origin and clipped run extent
  logic [COLOR_W-1:0] color_q;
  logic               frame_end_q;
  logic [X_W-1:0]     x0_q;
  logic [Y_W-1:0]     y0_q;
  logic [S_W-1:0]     nx_q, ny_q, nx_d, ny_d;
  logic [ADDR_W-1:0]  row_addr_q;
  logic [RA_W-1:0]    ra_prod;
  logic [X_W-1:0]     sw_x, rem_x;
  logic [Y_W-1:0]     sh_y, rem_y;
  logic [S_W-1:0]     dx_q, dy_q;
  logic               last_write;

  always_comb begin
    sw_x    = X_W'(sw_c);
    sh_y    = Y_W'(sh_c);
    rem_x   = sw_x - x0_q;
    rem_y   = sh_y - y0_q;
    ra_prod = RA_W'(y0_q) * RA_W'(sw_c);
    if (x0_q >= sw_x) begin
      nx_d = '0;
    end else if (rem_x < X_W'(scale_q)) begin
      nx_d = S_W'(rem_x);
    end else begin
      nx_d = scale_q;
    end
    if (y0_q >= sh_y) begin
      ny_d = '0;
    end else if (rem_y < Y_W'(scale_q)) begin
      ny_d = S_W'(rem_y);
    end else begin
      ny_d = scale_q;
    end
    last_write = (dx_q == nx_q - S_W'(1)) && (dy_q == ny_q - S_W'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      color_q     <= widen_rgb565(source_pixel_i);
      frame_end_q <= end_frame;
      x0_q        <= x0_new;
      y0_q        <= y0_new;
    end
    if (cmd_i.setup) begin
      nx_q       <= nx_d;
      ny_q       <= ny_d;
      row_addr_q <= ADDR_W'(ra_prod);
      dx_q       <= '0;
      dy_q       <= '0;
    end else if (cmd_i.emit) begin
      if (dx_q == nx_q - S_W'(1)) begin
        dx_q       <= '0;
        dy_q       <= dy_q + S_W'(1);
        row_addr_q <= row_addr_q + ADDR_W'(sw_c);
      end else begin
        dx_q <= dx_q + S_W'(1);
      end
    end
  end

  // output word register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      write_address_o <= row_addr_q + ADDR_W'(x0_q) + ADDR_W'(dx_q);
      write_color_o   <= color_q;
      last_of_run_o   <= last_write;
      frame_done_o    <= last_write && frame_end_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.derive_done = derive_done;
  assign sts_o.run_empty   = (nx_q == '0) || (ny_q == '0);
  assign sts_o.last_write  = last_write;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire
